[hw/rtl/gesture_sector_selector_defines.svh]
// ----------------------------------------------------------------------------
// gesture sector selector assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef GESTURE_SECTOR_SELECTOR_DEFINES_SVH
`define GESTURE_SECTOR_SELECTOR_DEFINES_SVH

// same-cycle implication
`define GSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gss assertion failed");

// next-cycle implication
`define GSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gss assertion failed");

`endif

[hw/rtl/gss_pkg.sv]
// ----------------------------------------------------------------------------
// gss_pkg
// types, constants and the angle table of the gesture sector selector
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int ACCUM_WIDTH     = 23;
    localparam int CORDIC_STEPS    = 20;
    localparam int ZFRAC           = 16;
    localparam int Z_W             = 27;
    localparam int NORM_BIT        = 29;
    localparam int ITER_W          = 5;
    localparam int RND_SH          = ZFRAC - ANGLE_FRAC_BITS;
    localparam int LIM_W           = 22;
    localparam int LW              = ACCUM_WIDTH - 1;
    localparam int CW              = ((LW > NORM_BIT + 1) ? LW : NORM_BIT + 1) + 3;
    localparam int SPAN_W          = 8 + ANGLE_FRAC_BITS;
    localparam int AIM_NUM_W       = ACCUM_WIDTH + 6;
    localparam int SEC_NUM_W       = SPAN_W + 9;
    localparam int DIV_NW          = (AIM_NUM_W > SEC_NUM_W) ? AIM_NUM_W : SEC_NUM_W;
    localparam int DIV_DW          = (LW > SPAN_W + 1) ? LW : SPAN_W + 1;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = 3'd4;

    localparam logic [1:0] DIV_SEC = 2'd0;
    localparam logic [1:0] DIV_YAW = 2'd1;
    localparam logic [1:0] DIV_PIT = 2'd2;

    localparam logic EV_AIM     = 1'b0;
    localparam logic EV_CONFIRM = 1'b1;

    typedef struct packed {
        logic               button_level;
        logic               sample_ok;
        logic signed [15:0] gyro_yaw;
        logic signed [15:0] gyro_pitch;
    } in_item_t;

    typedef struct packed {
        logic              event_kind;
        logic        [5:0] sector;
        logic signed [7:0] aim_yaw;
        logic signed [7:0] aim_pitch;
    } out_item_t;

    typedef struct packed {
        logic       accept;
        logic       prep;
        logic       norm;
        logic       cordic;
        logic       sect;
        logic       div_start;
        logic [1:0] div_sel;
        logic       put;
    } ctrl_cmd_t;

    typedef struct packed {
        logic conf;
        logic samp;
        logic norm_done;
        logic cordic_done;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
        logic [Z_W-1:0] v;
        unique case (i)
            5'd0:    v = Z_W'(2949120);
            5'd1:    v = Z_W'(1740967);
            5'd2:    v = Z_W'(919879);
            5'd3:    v = Z_W'(466945);
            5'd4:    v = Z_W'(234379);
            5'd5:    v = Z_W'(117304);
            5'd6:    v = Z_W'(58666);
            5'd7:    v = Z_W'(29335);
            5'd8:    v = Z_W'(14668);
            5'd9:    v = Z_W'(7334);
            5'd10:   v = Z_W'(3667);
            5'd11:   v = Z_W'(1833);
            5'd12:   v = Z_W'(917);
            5'd13:   v = Z_W'(458);
            5'd14:   v = Z_W'(229);
            5'd15:   v = Z_W'(115);
            5'd16:   v = Z_W'(57);
            5'd17:   v = Z_W'(29);
            5'd18:   v = Z_W'(14);
            5'd19:   v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/gss_div.sv]
// ----------------------------------------------------------------------------
// gss_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gss_div
    import gss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   trial;
    logic              qbit;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_NW-1]};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIV_NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops
            rem_next = qbit ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/gss_ctrl.sv]
// ----------------------------------------------------------------------------
// gss_ctrl
// sequencer for one tick: accept, angle, sector and aim divisions, output
// ----------------------------------------------------------------------------
module gss_ctrl
    import gss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_PREP   = 12'b000000000010,
        ST_NORM   = 12'b000000000100,
        ST_CORDIC = 12'b000000001000,
        ST_SECT   = 12'b000000010000,
        ST_LSEC   = 12'b000000100000,
        ST_WSEC   = 12'b000001000000,
        ST_LYAW   = 12'b000010000000,
        ST_WYAW   = 12'b000100000000,
        ST_LPIT   = 12'b001000000000,
        ST_WPIT   = 12'b010000000000,
        ST_PUT    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = DIV_SEC;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    if (stat.conf) state_next = ST_PUT;
                    else if (stat.samp) state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                cmd.norm = 1'b1;
                if (stat.norm_done) state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.cordic = 1'b1;
                if (stat.cordic_done) state_next = ST_SECT;
            end
            ST_SECT: begin
                cmd.sect   = 1'b1;
                state_next = ST_LSEC;
            end
            ST_LSEC: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WSEC;
            end
            ST_WSEC: begin
                if (stat.div_done) state_next = ST_LYAW;
            end
            ST_LYAW: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_YAW;
                state_next    = ST_WYAW;
            end
            ST_WYAW: begin
                cmd.div_sel = DIV_YAW;
                if (stat.div_done) state_next = ST_LPIT;
            end
            ST_LPIT: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PIT;
                state_next    = ST_WPIT;
            end
            ST_WPIT: begin
                cmd.div_sel = DIV_PIT;
                if (stat.div_done) state_next = ST_PUT;
            end
            ST_PUT: begin
                // wait until the output register can take the transaction
                if (stat.out_free) begin
                    cmd.put    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/gss_dp.sv]
// ----------------------------------------------------------------------------
// gss_dp
// tick state, config registers, cordic angle, divider feed and output register
// ----------------------------------------------------------------------------
module gss_dp
    import gss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  in_item_t              s_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output out_item_t             m_data,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat
);

    localparam int LX = (LIM_W > LW) ? LIM_W : LW;

    // config
    logic [7:0]       deb_ticks_reg, interval_reg, span_reg;
    logic [LIM_W-1:0] limit_reg;
    logic [6:0]       nsec_reg;

    // tick state
    logic                          seen_reg, seen_next;
    logic                          deb_reg, deb_next;
    logic [7:0]                    tsc_reg, tsc_next;
    logic                          locked_reg, locked_next;
    logic [7:0]                    tss_reg, tss_next;
    logic signed [ACCUM_WIDTH-1:0] yacc_reg, yacc_next;
    logic signed [ACCUM_WIDTH-1:0] pacc_reg, pacc_next;
    logic [5:0]                    held_reg;
    logic                          sv_reg, sv_next;

    // cordic
    logic signed [CW-1:0]  x_reg, y_reg;
    logic [CW-1:0]         m_reg;
    logic signed [Z_W-1:0] z_reg;
    logic [ITER_W-1:0]     iter_reg;
    logic                  yzero_reg;

    logic [SEC_NUM_W-1:0]  secnum_reg;
    logic signed [7:0]     aimy_reg;
    out_item_t             res_reg;
    logic                  mvalid_reg;
    out_item_t             mdata_reg;

    // effective config
    logic [LX-1:0]     lim_x, cap_x, lim_sel;
    logic [LW-1:0]     lim;
    logic [6:0]        n_eff;
    logic [7:0]        span_eff;
    logic [SPAN_W-1:0] s_val;

    always_comb begin
        lim_x    = LX'(limit_reg);
        cap_x    = LX'({LW{1'b1}});
        lim_sel  = (lim_x > cap_x) ? cap_x : lim_x;
        lim      = lim_sel[LW-1:0];
        n_eff    = (nsec_reg == 7'd0) ? 7'd1 : ((nsec_reg > 7'd64) ? 7'd64 : nsec_reg);
        span_eff = (span_reg == 8'd0) ? 8'd1 : span_reg;
        s_val    = SPAN_W'(span_eff) << ANGLE_FRAC_BITS;
    end

    // saturating add against +-lim
    function automatic logic signed [ACCUM_WIDTH-1:0] sat_add(
        input logic signed [ACCUM_WIDTH-1:0] acc,
        input logic signed [15:0]            d,
        input logic        [LW-1:0]          l
    );
        logic signed [ACCUM_WIDTH:0] sum, lp;
        sum = (ACCUM_WIDTH + 1)'(acc) + (ACCUM_WIDTH + 1)'(d);
        lp  = $signed({2'b00, l});
        if (sum > lp) sum = lp;
        if (sum < -lp) sum = -lp;
        return sum[ACCUM_WIDTH-1:0];
    endfunction

    // front end of a tick
    logic stable, pressed, released, lock1, sv1, due;
    logic conf, samp;
    logic [7:0] tss1;

    always_comb begin
        seen_next   = seen_reg;
        tsc_next    = tsc_reg;
        yacc_next   = yacc_reg;
        pacc_next   = pacc_reg;
        if (s_data.button_level != seen_reg) begin
            seen_next = s_data.button_level;
            tsc_next  = 8'd0;
        end else if (tsc_reg != 8'hff) begin
            tsc_next = tsc_reg + 8'd1;
        end
        stable   = (tsc_next >= deb_ticks_reg) ? seen_next : deb_reg;
        pressed  = stable & ~deb_reg;
        released = ~stable & deb_reg;
        deb_next = stable;
        lock1    = locked_reg;
        sv1      = sv_reg;
        conf     = 1'b0;
        if (pressed && !locked_reg) begin
            yacc_next = '0;
            pacc_next = '0;
            lock1     = 1'b1;
            sv1       = 1'b0;
        end
        if (released && lock1) begin
            lock1 = 1'b0;
            conf  = sv1;
            sv1   = 1'b0;
        end
        tss1     = (tss_reg != 8'hff) ? tss_reg + 8'd1 : tss_reg;
        due      = lock1 && (tss1 >= interval_reg);
        tss_next = due ? 8'd0 : tss1;
        samp     = due && s_data.sample_ok;
        if (samp) begin
            yacc_next = sat_add(yacc_next, s_data.gyro_yaw, lim);
            pacc_next = sat_add(pacc_next, s_data.gyro_pitch, lim);
            sv1       = 1'b1;
        end
        locked_next = lock1;
        sv_next     = sv1;
    end

    // cordic prep values
    logic signed [CW-1:0] xa, ya, xp, yp, ay;
    logic [CW-1:0]        mp;
    logic signed [Z_W-1:0] zp;
    localparam logic signed [Z_W-1:0] Z180 = Z_W'(180 << ZFRAC);

    always_comb begin
        xa = CW'(pacc_reg);
        ya = CW'(yacc_reg);
        zp = '0;
        xp = xa;
        yp = ya;
        if (xa < 0) begin
            zp = (ya > 0) ? Z180 : -Z180;
            xp = -xa;
            yp = -ya;
        end
        ay = (yp < 0) ? -yp : yp;
        mp = (xp > ay) ? xp : ay;
        if (ya == 0) zp = (xa < 0) ? Z180 : '0;
    end

    // one rotation
    logic signed [CW-1:0]  xs, ys;
    logic signed [Z_W-1:0] at;
    logic                  thr_ok, small_m;

    always_comb begin
        xs      = x_reg >>> iter_reg;
        ys      = y_reg >>> iter_reg;
        at      = $signed(atan_entry(iter_reg));
        thr_ok  = (m_reg >= (CW'(1) << NORM_BIT));
        small_m = (m_reg < (CW'(1) << (NORM_BIT - 4)));
    end

    // angle to sector numerator
    logic signed [Z_W-1:0]    zr, a_cl, s_z;
    logic [SPAN_W:0]          a_off;
    logic [SPAN_W+7:0]        prod;

    always_comb begin
        zr    = (z_reg + Z_W'(1 << (RND_SH - 1))) >>> RND_SH;
        s_z   = $signed(Z_W'(s_val));
        a_cl  = (zr > s_z) ? s_z : ((zr < -s_z) ? -s_z : zr);
        a_off = (SPAN_W + 1)'(a_cl + s_z);
        prod  = (SPAN_W + 8)'(a_off) * (SPAN_W + 8)'(n_eff);
    end

    // divider feed
    logic [LW-1:0]       mag_y, mag_p, mag_sel;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_DW-1:0]   div_den;
    logic [AIM_NUM_W-1:0] aim_num;
    logic                div_done;
    logic [DIV_NW-1:0]   div_q;

    always_comb begin
        mag_y   = (yacc_reg < 0) ? LW'(-yacc_reg) : LW'(yacc_reg);
        mag_p   = (pacc_reg < 0) ? LW'(-pacc_reg) : LW'(pacc_reg);
        mag_sel = (cmd.div_sel == DIV_YAW) ? mag_y : mag_p;
        aim_num = (AIM_NUM_W'(mag_sel) << 7) - AIM_NUM_W'(mag_sel);
        if (cmd.div_sel == DIV_SEC) begin
            div_num = DIV_NW'(secnum_reg);
            div_den = DIV_DW'({s_val, 1'b0});
        end else begin
            div_num = DIV_NW'(aim_num);
            div_den = DIV_DW'(lim);
        end
    end

    gss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // post-division results
    logic [7:0]        t1, t2, t3;
    logic [7:0]        q8;
    logic signed [7:0] aim_v;

    always_comb begin
        t1    = {1'b0, div_q[6:0]} + 8'd1;
        t2    = (t1 >= {1'b0, n_eff}) ? t1 - {1'b0, n_eff} : t1;
        t3    = (t2 >= {1'b0, n_eff}) ? t2 - {1'b0, n_eff} : t2;
        q8    = (lim == '0) ? 8'd0 : div_q[7:0];
        if (cmd.div_sel == DIV_YAW) aim_v = (yacc_reg < 0) ? -$signed(q8) : $signed(q8);
        else aim_v = (pacc_reg < 0) ? -$signed(q8) : $signed(q8);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_ticks_reg <= 8'd15;
            interval_reg  <= 8'd4;
            limit_reg     <= LIM_W'(982500);
            nsec_reg      <= 7'd12;
            span_reg      <= 8'd60;
            seen_reg      <= 1'b0;
            deb_reg       <= 1'b0;
            tsc_reg       <= 8'hff;
            locked_reg    <= 1'b0;
            tss_reg       <= 8'hff;
            yacc_reg      <= '0;
            pacc_reg      <= '0;
            held_reg      <= '0;
            sv_reg        <= 1'b0;
            mvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_DEBOUNCE: deb_ticks_reg <= cfg_data[7:0];
                    CFG_INTERVAL: interval_reg  <= cfg_data[7:0];
                    CFG_LIMIT:    limit_reg     <= cfg_data[LIM_W-1:0];
                    CFG_SECTORS:  nsec_reg      <= cfg_data[6:0];
                    CFG_SPAN:     span_reg      <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                seen_reg   <= seen_next;
                deb_reg    <= deb_next;
                tsc_reg    <= tsc_next;
                locked_reg <= locked_next;
                tss_reg    <= tss_next;
                yacc_reg   <= yacc_next;
                pacc_reg   <= pacc_next;
                sv_reg     <= sv_next;
            end
            if (div_done && cmd.div_sel == DIV_SEC) held_reg <= t3[5:0];
            if (cmd.put) mvalid_reg <= 1'b1;
            else if (m_ready) mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && conf) begin
            res_reg <= '{event_kind: EV_CONFIRM, sector: held_reg, aim_yaw: 8'sd0,
                         aim_pitch: 8'sd0};
        end
        if (cmd.prep) begin
            x_reg     <= xp;
            y_reg     <= yp;
            m_reg     <= mp;
            z_reg     <= zp;
            iter_reg  <= '0;
            yzero_reg <= (ya == 0);
        end
        if (cmd.norm && !yzero_reg && !thr_ok) begin
            // coarse steps of four, then single bits up to the threshold
            if (small_m) begin
                x_reg <= x_reg <<< 4;
                y_reg <= y_reg <<< 4;
                m_reg <= m_reg << 4;
            end else begin
                x_reg <= x_reg <<< 1;
                y_reg <= y_reg <<< 1;
                m_reg <= m_reg << 1;
            end
        end
        if (cmd.cordic && !yzero_reg) begin
            if (y_reg > 0) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.sect) secnum_reg <= SEC_NUM_W'(prod) + SEC_NUM_W'(s_val);
        if (div_done && cmd.div_sel == DIV_YAW) aimy_reg <= aim_v;
        if (div_done && cmd.div_sel == DIV_PIT) begin
            res_reg <= '{event_kind: EV_AIM, sector: 6'd0, aim_yaw: aimy_reg,
                         aim_pitch: aim_v};
        end
        if (cmd.put) mdata_reg <= res_reg;
    end

    always_comb begin
        stat.conf        = conf;
        stat.samp        = samp;
        stat.norm_done   = yzero_reg || thr_ok;
        stat.cordic_done = yzero_reg || (iter_reg == ITER_W'(CORDIC_STEPS - 1));
        stat.div_done    = div_done;
        stat.out_free    = !mvalid_reg || m_ready;
    end

    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

endmodule

[hw/rtl/gesture_sector_selector.sv]
// ----------------------------------------------------------------------------
// gesture_sector_selector
// debounced button lock, saturating gyro integration, aim and sector results
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  s_       in         s_valid / s_ready     in_item_t  (one tick)
//  m_       out        m_valid / m_ready     out_item_t (aim or confirm)
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  a tick that makes no result goes straight back to idle, a confirm waits only for the output register
//  a sample runs prepare, normalize (at most 10 shifts), the cordic rotations, the sector
//  step and three divisions on the shared one-bit-per-cycle divider, then the output
//  reset is synchronous on aresetn low and restores all config registers
//  s_ready drops while a tick is at work or its result waits for the register
//  a full output register holds its transaction until m_ready
module gesture_sector_selector
    import gss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    gss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gss_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[hw/rtl/gss_checker.sv]
// ----------------------------------------------------------------------------
// gss_checker
// port-level checks of the gesture sector selector result channel
// ----------------------------------------------------------------------------
`include "gesture_sector_selector_defines.svh"

module gss_checker
    import gss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data
);

    logic aim_out, conf_out;

    assign aim_out  = m_valid && (m_data.event_kind == EV_AIM);
    assign conf_out = m_valid && (m_data.event_kind == EV_CONFIRM);

    `GSS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `GSS_ASSERT_NOW(a_confirm_no_aim, conf_out, m_data.aim_yaw == 8'sd0 && m_data.aim_pitch == 8'sd0)
    `GSS_ASSERT_NOW(a_aim_no_sector, aim_out, m_data.sector == 6'd0)
    `GSS_ASSERT_NOW(a_aim_range, aim_out, m_data.aim_yaw != 8'sh80 && m_data.aim_pitch != 8'sh80)

endmodule

bind gesture_sector_selector gss_checker u_gss_checker (.*);

[sim/tb_gesture_sector_selector.sv]
// ----------------------------------------------------------------------------
// tb_gesture_sector_selector
// drives button/gyro ticks through several register settings and compares
// every aim and confirm transaction with an in-bench model of the selector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gesture_sector_selector;
    import gss_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 300;

    localparam longint ATAN_DEG16 [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    out_item_t pending_events[$];
    int        errors;
    int        ticks_sent;
    bit        no_idle;

    // model registers and state
    int     r_debounce, r_interval, r_limit, r_sectors, r_span;
    bit     seen_lvl, deb_lvl, is_locked, have_sector;
    int     since_change, since_sample;
    longint yaw_acc, pitch_acc;
    logic [5:0] held_sec;

    gesture_sector_selector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic longint pointing_angle(longint y, longint x);
        longint z, m, ay, nx, ny;
        int sh;
        z = 0;
        sh = 0;
        if (y == 0) return (x < 0) ? (longint'(180) <<< ZFRAC) : 0;
        if (x < 0) begin
            z = (y > 0) ? (longint'(180) <<< ZFRAC) : -(longint'(180) <<< ZFRAC);
            x = -x;
            y = -y;
        end
        ay = (y < 0) ? -y : y;
        m = (x > ay) ? x : ay;
        while (m < (longint'(1) <<< 29)) begin
            m = m <<< 1;
            sh++;
        end
        x = x <<< sh;
        y = y <<< sh;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_DEG16[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_DEG16[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic logic [5:0] sector_for(longint y, longint x);
        longint a, n, sp, span_fx, idx;
        a = (pointing_angle(y, x) + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH;
        n = (r_sectors < 1) ? 1 : (r_sectors > 64) ? 64 : r_sectors;
        sp = (r_span == 0) ? 1 : r_span;
        span_fx = sp <<< ANGLE_FRAC_BITS;
        if (a > span_fx) a = span_fx;
        if (a < -span_fx) a = -span_fx;
        idx = ((a + span_fx) * n + span_fx) / (2 * span_fx);
        return 6'((idx + 1) % n);
    endfunction

    function automatic logic signed [7:0] aim_scale(longint acc, longint lim);
        longint q;
        if (lim <= 0) return '0;
        q = ((acc < 0) ? -acc : acc) * 127 / lim;
        return 8'((acc < 0) ? -q : q);
    endfunction

    function automatic longint clamp_add(longint acc, longint d, longint lim);
        acc += d;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        return acc;
    endfunction

    task automatic predict_tick(input in_item_t t);
        bit        stable, pressed, released;
        longint    lim;
        out_item_t ev;
        lim = r_limit;
        if (lim > (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1)
            lim = (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1;
        if (t.button_level != seen_lvl) begin
            seen_lvl = t.button_level;
            since_change = 0;
        end else if (since_change < 255) begin
            since_change++;
        end
        stable = (since_change >= r_debounce) ? seen_lvl : deb_lvl;
        pressed = stable && !deb_lvl;
        released = !stable && deb_lvl;
        deb_lvl = stable;
        if (pressed && !is_locked) begin
            yaw_acc = 0;
            pitch_acc = 0;
            is_locked = 1;
            have_sector = 0;
        end
        if (released && is_locked) begin
            is_locked = 0;
            if (have_sector) begin
                ev = '{event_kind: EV_CONFIRM, sector: held_sec, aim_yaw: '0, aim_pitch: '0};
                pending_events.push_back(ev);
            end
            have_sector = 0;
        end
        if (since_sample < 255) since_sample++;
        if (is_locked && since_sample >= r_interval) begin
            since_sample = 0;
            if (t.sample_ok) begin
                yaw_acc = clamp_add(yaw_acc, longint'(t.gyro_yaw), lim);
                pitch_acc = clamp_add(pitch_acc, longint'(t.gyro_pitch), lim);
                held_sec = sector_for(yaw_acc, pitch_acc);
                have_sector = 1;
                ev = '{event_kind: EV_AIM, sector: '0,
                       aim_yaw: aim_scale(yaw_acc, lim),
                       aim_pitch: aim_scale(pitch_acc, lim)};
                pending_events.push_back(ev);
            end
        end
    endtask

    task automatic send_tick(input bit lvl, input bit ok,
                             input logic [15:0] yaw, input logic [15:0] pitch);
        in_item_t t;
        t = '{button_level: lvl, sample_ok: ok, gyro_yaw: yaw, gyro_pitch: pitch};
        if (!no_idle && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        predict_tick(t);
        ticks_sent++;
    endtask

    task automatic wait_idle;
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_DEBOUNCE: r_debounce = value & 'hFF;
            CFG_INTERVAL: r_interval = value & 'hFF;
            CFG_LIMIT:    r_limit    = value & 'h3FFFFF;
            CFG_SECTORS:  r_sectors  = value & 'h7F;
            CFG_SPAN:     r_span     = value & 'hFF;
            default: ;
        endcase
    endtask

    task automatic configure(input int deb, input int intv, input int lim,
                             input int nsec, input int span);
        wait_idle();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_INTERVAL, intv);
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_SECTORS, nsec);
        write_reg(CFG_SPAN, span);
    endtask

    function automatic logic [15:0] random_rate;
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(400)) - 200);
            2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return '0;
        endcase
    endfunction

    task automatic hold_level(input bit lvl, input int n);
        repeat (n) send_tick(lvl, $urandom_range(99) < 85, random_rate(), random_rate());
    endtask

    // one press/release; a broken one lets go before the debounce settles
    task automatic gesture(input bit broken);
        hold_level(1'b0, r_debounce + 1 + $urandom_range(3));
        if ($urandom_range(3) == 0) begin
            hold_level(1'b1, (r_debounce > 1) ? $urandom_range(r_debounce - 1) : 0);
            hold_level(1'b0, 1 + $urandom_range(2));
        end
        if (broken) begin
            hold_level(1'b1, (r_debounce > 1) ? $urandom_range(1, r_debounce - 1) : 0);
        end else begin
            hold_level(1'b1, r_debounce + 1 + $urandom_range(30));
        end
        hold_level(1'b0, r_debounce + 1 + $urandom_range(3));
    endtask

    task automatic test_directed_angles;
        configure(1, 1, 982500, 12, 60);
        hold_level(1'b0, 3);
        send_tick(1'b1, 1'b1, 16'sd0, 16'sd0);
        send_tick(1'b1, 1'b1, 16'sd0, 16'sd0);       // zero vector
        send_tick(1'b1, 1'b1, 16'sd0, -16'sd32768);  // y zero, x negative
        send_tick(1'b1, 1'b1, 16'sd32767, 16'sd0);
        send_tick(1'b1, 1'b1, -16'sd32768, -16'sd32768);
        send_tick(1'b1, 1'b0, 16'sd32767, 16'sd32767); // failed read
        send_tick(1'b1, 1'b1, 16'sd32767, 16'sd32767);
        send_tick(1'b0, 1'b1, 16'sd5, 16'sd5);
        send_tick(1'b0, 1'b1, 16'sd0, 16'sd0);
        // press with no sample before the release gives no confirm
        configure(2, 255, 982500, 12, 60);
        hold_level(1'b0, 3);
        hold_level(1'b1, 3);
        hold_level(1'b0, 3);
    endtask

    task automatic test_zero_and_overrange_regs;
        configure(0, 0, 0, 0, 0);
        write_reg(CFG_UNUSED, 'h3FFFFF);
        repeat (3) gesture(1'b0);
        configure(1, 1, 3, 127, 1);
        repeat (3) gesture(1'b0);
    endtask

    task automatic test_saturation_extremes;
        configure(1, 1, 4194303, 64, 180);
        repeat (2) begin
            hold_level(1'b0, 3);
            repeat (20) send_tick(1'b1, 1'b1, 16'h7FFF, 16'h8000);
            hold_level(1'b0, 3);
        end
        configure(255, 255, 1, 1, 1);
        hold_level(1'b0, 2);
        hold_level(1'b1, 260);
        hold_level(1'b0, 260);
    endtask

    task automatic test_random_gestures(input int n_ticks);
        int stop_at;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(9) == 0)
                hold_level($urandom_range(1), 1 + $urandom_range(5));
            else
                gesture($urandom_range(9) == 0);
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        errors = 0;
        ticks_sent = 0;
        no_idle = 0;
        r_debounce = 15; r_interval = 4; r_limit = 982500; r_sectors = 12; r_span = 60;
        seen_lvl = 0; deb_lvl = 0; is_locked = 0; have_sector = 0;
        since_change = 255; since_sample = 255;
        yaw_acc = 0; pitch_acc = 0; held_sec = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        no_idle = 1;
        test_random_gestures(100);
        no_idle = 0;
        test_directed_angles();
        test_zero_and_overrange_regs();
        test_saturation_extremes();
        configure(3, 2, 50000, 7, 180);
        test_random_gestures(120);
        configure(2, 1, 8000, 64, 45);
        test_random_gestures(120);
        configure(1 + $urandom_range(4), 1 + $urandom_range(6), 1 + $urandom_range(4194302),
                  1 + $urandom_range(63), 1 + $urandom_range(179));
        test_random_gestures(120);

        wait_idle();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= no_idle || ($urandom_range(99) >= 23);
    end

    always @(posedge aclk) begin
        out_item_t exp_ev;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected transaction kind=%0d", m_data.event_kind);
                errors++;
            end else begin
                exp_ev = pending_events.pop_front();
                if (m_data.event_kind !== exp_ev.event_kind) begin
                    $error("event_kind exp %0d got %0d", exp_ev.event_kind, m_data.event_kind);
                    errors++;
                end
                if (m_data.sector !== exp_ev.sector) begin
                    $error("sector exp %0d got %0d", exp_ev.sector, m_data.sector);
                    errors++;
                end
                if (m_data.aim_yaw !== exp_ev.aim_yaw) begin
                    $error("aim_yaw exp %0d got %0d", exp_ev.aim_yaw, m_data.aim_yaw);
                    errors++;
                end
                if (m_data.aim_pitch !== exp_ev.aim_pitch) begin
                    $error("aim_pitch exp %0d got %0d", exp_ev.aim_pitch, m_data.aim_pitch);
                    errors++;
                end
            end
        end
    end

    initial begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/gss_pkg.sv
hw/rtl/gss_div.sv
hw/rtl/gss_ctrl.sv
hw/rtl/gss_dp.sv
hw/rtl/gesture_sector_selector.sv
hw/rtl/gss_checker.sv
sim/tb_gesture_sector_selector.sv
